### sv/bdq_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the bounded double-ended queue
package bdq_pkg;

	localparam int unsigned VALUE_W = 16;
	localparam int unsigned CAP_W   = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		FUNC_PUSH_LEFT  = 2'd0,
		FUNC_PUSH_RIGHT = 2'd1,
		FUNC_POP_LEFT   = 2'd2,
		FUNC_POP_RIGHT  = 2'd3
	} bdq_func_t;

	typedef enum logic [1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} bdq_status_t;

	typedef struct packed {
		bdq_func_t                  func;
		logic signed [VALUE_W-1:0]  push_value;
	} bdq_cmd_t;

	typedef struct packed {
		bdq_status_t                status;
		logic signed [VALUE_W-1:0]  item_value;
	} bdq_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_RESP
	} bdq_state_t;

	// controller to datapath
	typedef struct packed {
		logic        push;      // write the command value at one end
		logic        pop;       // read one end and retire it
		logic        left;      // operate on the left end
		logic        load_imm;  // load response from command / status
		logic        load_rd;   // load response from memory read data
		bdq_status_t status;
	} bdq_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
	} bdq_flags_t;

endpackage

### sv/bdq_datapath.sv
`timescale 1ns / 1ps
// ring buffer storage, end pointers, fill count, capacity and response register
module bdq_datapath import bdq_pkg::*; #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bdq_ctl_t             ctl,
	input  bdq_cmd_t             cmd,
	input  logic                 cfg_wr,
	input  logic [CAP_W-1:0]     cfg_data,
	output bdq_flags_t           flags,
	output bdq_rsp_t             rsp
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned LW = (CW > CAP_W) ? CW : CAP_W;
	localparam int unsigned SW = ((AW > CW) ? AW : CW) + 1;

	logic [VALUE_W-1:0] mem_q [DEPTH];
	logic [VALUE_W-1:0] rd_q;
	logic [AW-1:0]      front_q;
	logic [CW-1:0]      fill_q;
	logic [CAP_W-1:0]   cap_q;
	bdq_rsp_t           rsp_q;

	logic [AW-1:0]      front_dec;
	logic [AW-1:0]      front_inc;
	logic [SW-1:0]      tail_sum;
	logic [SW-1:0]      back_sum;
	logic [AW-1:0]      tail_pos;
	logic [AW-1:0]      back_pos;
	logic [AW-1:0]      addr;

	// full when fill reaches capacity or the physical depth
	assign flags.full  = (LW'(fill_q) >= LW'(cap_q)) || (fill_q == CW'(DEPTH));
	assign flags.empty = (fill_q == '0);

	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

	// slot just past the rightmost entry, and the rightmost entry itself
	always_comb begin
		tail_sum = SW'(front_q) + SW'(fill_q);
		back_sum = tail_sum - SW'(1);
		tail_pos = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
		back_pos = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
	end

	always_comb begin
		unique case ({ctl.push, ctl.left})
			2'b11:   addr = front_dec;
			2'b10:   addr = tail_pos;
			2'b01:   addr = front_q;
			default: addr = back_pos;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[addr] <= cmd.push_value;
		end
		if (ctl.pop) begin
			rd_q <= mem_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			fill_q  <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			if (cfg_wr) begin
				cap_q <= cfg_data;
			end
			if (ctl.push) begin
				fill_q <= fill_q + CW'(1);
				if (ctl.left) begin
					front_q <= front_dec;
				end
			end else if (ctl.pop) begin
				fill_q <= fill_q - CW'(1);
				if (ctl.left) begin
					front_q <= front_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_imm) begin
			rsp_q.status     <= ctl.status;
			rsp_q.item_value <= (ctl.status == STATUS_DONE) ? cmd.push_value : '0;
		end else if (ctl.load_rd) begin
			rsp_q.status     <= STATUS_DONE;
			rsp_q.item_value <= rd_q;
		end
	end

	assign rsp = rsp_q;

endmodule

### sv/bdq_ctrl.sv
`timescale 1ns / 1ps
// command sequencer for the deque
module bdq_ctrl import bdq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  bdq_func_t  func,
	input  logic       rsp_ready,
	input  bdq_flags_t flags,
	output logic       cmd_ready,
	output logic       rsp_valid,
	output bdq_ctl_t   ctl
);

	bdq_state_t state_q;
	bdq_state_t state_d;
	logic       is_push;

	assign is_push = (func == FUNC_PUSH_LEFT) || (func == FUNC_PUSH_RIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = (!is_push && !flags.empty) ? ST_READ : ST_RESP;
				end
			end
			ST_READ: state_d = ST_RESP;
			ST_RESP: begin
				if (rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd_ready    = (state_q == ST_IDLE);
		rsp_valid    = (state_q == ST_RESP);
		ctl          = '0;
		ctl.status   = STATUS_DONE;
		ctl.left     = (func == FUNC_PUSH_LEFT) || (func == FUNC_POP_LEFT);
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (is_push) begin
						ctl.load_imm = 1'b1;
						if (flags.full) begin
							ctl.status = STATUS_FULL;
						end else begin
							ctl.push = 1'b1;
						end
					end else if (flags.empty) begin
						ctl.load_imm = 1'b1;
						ctl.status   = STATUS_EMPTY;
					end else begin
						ctl.pop = 1'b1;
					end
				end
			end
			ST_READ: ctl.load_rd = 1'b1;
			default: ctl.load_rd = 1'b0;
		endcase
	end

endmodule

### sv/bounded_double_ended_queue.sv
`timescale 1ns / 1ps
// top level of the bounded double-ended queue
// Bounded double-ended queue on a ring buffer of DEPTH 16-bit slots. Each command word
// pushes a signed value at the left or right end or pops one end, and gives exactly one
// response word: a status (done, refused because full, refused because empty) and the value
// pushed or popped, zero when refused. A refused command leaves the queue unchanged. The
// capacity register (reset 16) limits the fill; values above DEPTH act as DEPTH, zero
// refuses every push, and lowering it below the current fill only blocks pushes until pops
// bring the fill down. One command is handled at a time: a push or a refused command goes
// from acceptance through the response state back to idle, and a pop also passes through
// the read state first, for the registered read port of the slot memory. The controller
// holds the response until rsp_ready takes it, and only then accepts the next command.
// Capacity writes are always accepted and should come while the queue is idle.
module bounded_double_ended_queue import bdq_pkg::*; #(
	parameter int unsigned DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  bdq_cmd_t           cmd,
	// response channel
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output bdq_rsp_t           rsp,
	// capacity register write
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CAP_W-1:0]   cfg_data
);

	bdq_ctl_t   ctl;
	bdq_flags_t flags;

	// capacity register takes a word every cycle
	assign cfg_ready = 1'b1;

	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.func      (cmd.func),
		.rsp_ready (rsp_ready),
		.flags     (flags),
		.cmd_ready (cmd_ready),
		.rsp_valid (rsp_valid),
		.ctl       (ctl)
	);

	// ring storage, pointers and the response register
	bdq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.cmd      (cmd),
		.cfg_wr   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.flags    (flags),
		.rsp      (rsp)
	);

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the bounded double-ended queue
module tb_top import bdq_pkg::*;;

	localparam int DEPTH       = 16;
	localparam int HOLD_CYCLES = 60;    // long receiver hold-off
	localparam int IDLE_LIMIT  = 3000;  // cycles with no word moving on any channel
	localparam int SEG_LEN     = 90;    // random words per capacity setting

	// one line of the directed table: a capacity write or a command word
	typedef struct {
		logic                is_cap;
		bdq_func_t           func;
		logic signed [15:0]  value;    // push value, or the capacity for a write
		logic                known;    // expected response typed in below
		bdq_rsp_t            want;
	} plan_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cmd_valid = 1'b0;
	logic             cmd_ready;
	bdq_cmd_t         cmd = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	bdq_rsp_t         rsp;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data = '0;

	// predictor state: ring of slots, leftmost index, fill and capacity
	logic signed [15:0] ring_slots [DEPTH];
	logic [3:0]         ring_head = '0;
	logic [4:0]         ring_fill = '0;
	logic [CAP_W-1:0]   cap_setting = CAP_RESET;

	bdq_rsp_t  pending_rsps [$];   // responses still owed by the queue, oldest first
	plan_row_t plan [$];

	int errors = 0;
	int send_idle_pct = 0;
	int rsp_idle_pct = 0;
	int hold_tickets = 0;          // bumped by the stimulus to ask for a long hold-off
	int hold_served = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	bdq_rsp_t want_rsp;

	bounded_double_ended_queue #(.DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// apply one command to the predictor and return the response it owes
	function automatic bdq_rsp_t deque_apply(bdq_cmd_t c);
		bdq_rsp_t   r;
		logic [4:0] limit;
		logic [3:0] slot;
		r.status     = STATUS_DONE;
		r.item_value = '0;
		// capacity above the ring size acts as the ring size
		limit = (cap_setting > 5'(DEPTH)) ? 5'(DEPTH) : cap_setting;
		case (c.func)
			FUNC_PUSH_LEFT, FUNC_PUSH_RIGHT: begin
				// a lowered capacity below the fill refuses pushes too
				if (ring_fill >= limit) begin
					r.status = STATUS_FULL;
				end else begin
					if (c.func == FUNC_PUSH_LEFT) begin
						ring_head = ring_head - 4'd1;
						slot = ring_head;
					end else begin
						slot = 4'(ring_head + ring_fill);
					end
					ring_slots[slot] = c.push_value;
					ring_fill = ring_fill + 5'd1;
					r.item_value = c.push_value;
				end
			end
			default: begin
				if (ring_fill == 5'd0) begin
					r.status = STATUS_EMPTY;
				end else begin
					if (c.func == FUNC_POP_LEFT) begin
						r.item_value = ring_slots[ring_head];
						ring_head = ring_head + 4'd1;
					end else begin
						r.item_value = ring_slots[4'(ring_head + ring_fill - 5'd1)];
					end
					ring_fill = ring_fill - 5'd1;
				end
			end
		endcase
		return r;
	endfunction

	// random command word, pushes with the given weight in percent
	function automatic bdq_cmd_t random_word(int push_pct);
		bdq_cmd_t c;
		if ($urandom_range(99) < push_pct)
			c.func = $urandom_range(1) ? FUNC_PUSH_LEFT : FUNC_PUSH_RIGHT;
		else
			c.func = $urandom_range(1) ? FUNC_POP_LEFT : FUNC_POP_RIGHT;
		c.push_value = 16'($urandom);
		// now and then a value at the edge of the range
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(3))
				0: c.push_value = 16'sh7fff;
				1: c.push_value = -16'sh8000;
				2: c.push_value = 16'sh0000;
				default: c.push_value = -16'sh0001;
			endcase
		end
		return c;
	endfunction

	// offer one command word, with a random gap first, and hold it until taken;
	// valid stays high afterwards so the next word can follow back to back
	task automatic offer_word(bdq_cmd_t c, logic known, bdq_rsp_t typed);
		bdq_rsp_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
		// word taken at this edge: work out what it owes
		r = deque_apply(c);
		pending_rsps.push_back(known ? typed : r);
	endtask

	// drop valid and wait until every owed response has come back
	task automatic drain_all();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending_rsps.size() != 0);
	endtask

	// capacity writes only go in while the queue is idle
	task automatic write_capacity(logic [CAP_W-1:0] cap);
		drain_all();
		repeat (3) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_setting = cap;
		@(posedge clk);
	endtask

	task automatic plan_cap(logic [CAP_W-1:0] cap);
		plan_row_t p;
		p = '{1'b1, FUNC_PUSH_LEFT, 16'(cap), 1'b0, '0};
		plan.push_back(p);
	endtask

	task automatic plan_word(bdq_func_t f, logic signed [15:0] v);
		plan_row_t p;
		p = '{1'b0, f, v, 1'b0, '0};
		plan.push_back(p);
	endtask

	task automatic plan_known(bdq_func_t f, logic signed [15:0] v, bdq_status_t s,
			logic signed [15:0] item);
		plan_row_t p;
		p.is_cap = 1'b0;
		p.func = f;
		p.value = v;
		p.known = 1'b1;
		p.want.status = s;
		p.want.item_value = item;
		plan.push_back(p);
	endtask

	// receiver: random ready, plus a long hold-off when the stimulus asks for one
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			rsp_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (hold_served != hold_tickets) begin
			hold_served = hold_tickets;
			hold_left = HOLD_CYCLES - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
		end
	end

	// response checker: each taken word against the oldest owed response
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsps.size() == 0) begin
				$display("%0t: response word with nothing owed, got status %0d value %0d",
					$time, rsp.status, rsp.item_value);
				errors = errors + 1;
			end else begin
				want_rsp = pending_rsps.pop_front();
				if (rsp.status !== want_rsp.status) begin
					$display("%0t: status mismatch, expected %0d got %0d",
						$time, want_rsp.status, rsp.status);
					errors = errors + 1;
				end
				if (rsp.item_value !== want_rsp.item_value) begin
					$display("%0t: item_value mismatch, expected %0d got %0d",
						$time, want_rsp.item_value, rsp.item_value);
					errors = errors + 1;
				end
			end
		end
	end

	// watchdog: too long with no word moving on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int        seg;
		int        n;
		int        push_pct;
		int        run_left;
		bdq_cmd_t  c;
		plan_row_t row;
		logic [CAP_W-1:0] cap;

		// directed table, reset capacity of 16 first
		plan_known(FUNC_POP_LEFT, 16'sh0000, STATUS_EMPTY, 16'sh0000);
		plan_known(FUNC_POP_RIGHT, 16'sh7fff, STATUS_EMPTY, 16'sh0000);
		plan_known(FUNC_PUSH_LEFT, 16'sh7fff, STATUS_DONE, 16'sh7fff);
		plan_known(FUNC_PUSH_RIGHT, -16'sh8000, STATUS_DONE, -16'sh8000);
		plan_known(FUNC_PUSH_LEFT, -16'sh0001, STATUS_DONE, -16'sh0001);
		plan_known(FUNC_PUSH_RIGHT, 16'sh0000, STATUS_DONE, 16'sh0000);
		plan_word(FUNC_POP_LEFT, -16'sh0001);
		plan_word(FUNC_POP_RIGHT, 16'sh5555);
		plan_word(FUNC_POP_RIGHT, 16'sh0000);
		plan_word(FUNC_POP_LEFT, 16'sh0000);
		// capacity zero refuses every push
		plan_cap(5'd0);
		plan_known(FUNC_PUSH_LEFT, 16'sh5555, STATUS_FULL, 16'sh0000);
		plan_known(FUNC_PUSH_RIGHT, -16'sh5556, STATUS_FULL, 16'sh0000);
		plan_known(FUNC_POP_RIGHT, 16'sh0000, STATUS_EMPTY, 16'sh0000);
		// capacity above the ring size
		plan_cap(5'd31);
		plan_known(FUNC_PUSH_RIGHT, 16'sh00ff, STATUS_DONE, 16'sh00ff);
		plan_known(FUNC_PUSH_RIGHT, -16'sh0100, STATUS_DONE, -16'sh0100);
		plan_known(FUNC_PUSH_LEFT, 16'sh0f0f, STATUS_DONE, 16'sh0f0f);
		// capacity lowered below the fill: pushes blocked, pops keep working
		plan_cap(5'd2);
		plan_known(FUNC_PUSH_RIGHT, 16'sh0001, STATUS_FULL, 16'sh0000);
		plan_word(FUNC_POP_LEFT, 16'sh0000);
		plan_known(FUNC_PUSH_LEFT, 16'sh0002, STATUS_FULL, 16'sh0000);
		plan_word(FUNC_POP_RIGHT, 16'sh0000);
		plan_known(FUNC_PUSH_LEFT, 16'sh0003, STATUS_DONE, 16'sh0003);
		plan_word(FUNC_POP_LEFT, 16'sh0000);
		plan_word(FUNC_POP_LEFT, 16'sh0000);
		plan_known(FUNC_POP_RIGHT, 16'sh0000, STATUS_EMPTY, 16'sh0000);

		// hold reset once at the start, then release it
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table with no idling
		foreach (plan[i]) begin
			row = plan[i];
			if (row.is_cap) begin
				write_capacity(row.value[CAP_W-1:0]);
			end else begin
				c.func = row.func;
				c.push_value = row.value;
				offer_word(c, row.known, row.want);
			end
		end

		// random part: six capacity settings, idling changes every two
		for (seg = 0; seg < 6; seg++) begin
			send_idle_pct = (seg < 2) ? 14 : (seg < 4) ? 67 : 0;
			rsp_idle_pct  = (seg < 2) ? 67 : (seg < 4) ? 14 : 0;
			case (seg)
				0: cap = 5'd16;
				1: cap = 5'd1;
				2: cap = 5'd31;
				3: cap = 5'($urandom_range(2, 15));
				4: cap = 5'd0;
				default: cap = 5'($urandom_range(17, 30));
			endcase
			write_capacity(cap);
			// alternate push-heavy and pop-heavy runs so the fill hits both ends
			push_pct = 80;
			run_left = $urandom_range(4, 24);
			for (n = 0; n < ((seg == 4) ? 30 : SEG_LEN); n++) begin
				if (seg == 0 && n == 30)
					hold_tickets = hold_tickets + 1;   // receiver stalls, sender keeps offering
				if (seg == 2 && n == 40)
					drain_all();                       // sender pauses until all is back
				if (run_left == 0) begin
					push_pct = 100 - push_pct;
					run_left = $urandom_range(4, 24);
				end
				run_left = run_left - 1;
				offer_word(random_word(push_pct), 1'b0, '0);
			end
		end
		write_capacity(CAP_RESET);

		// wind down: wait until nothing is owed, then watch for stray words
		drain_all();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### filelist.f
sv/bdq_pkg.sv
sv/bdq_datapath.sv
sv/bdq_ctrl.sv
sv/bounded_double_ended_queue.sv
verif/tb_top.sv
